@@ rtl/core/gcc_pkg.sv @@
// Shared types and constants for the genotype concordance counter.
`timescale 1ns / 1ps

package gcc_pkg;

  localparam int CODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int DOSAGE_W = 2;
  localparam int REPORT_W = 32;
  localparam int CELLS    = 9;
  localparam int BIN_W    = $clog2(CELLS);

  // Largest dosage, which is also the last matrix row and column
  localparam logic [DOSAGE_W-1:0] DOSAGE_MAX = 2'd2;

  typedef enum logic [CODE_W-1:0] {
    CODE_HOM_REF = 2'd0,
    CODE_HET     = 2'd1,
    CODE_HOM_ALT = 2'd2,
    CODE_MISSING = 2'd3
  } geno_code_t;

  typedef enum logic [1:0] {
    KIND_SITE  = 2'd0,
    KIND_CHROM = 2'd1,
    KIND_TOTAL = 2'd2,
    KIND_CELL  = 2'd3
  } report_kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_first;
    logic [CODE_W-1:0] code_second;
    logic [BYTE_W-1:0] ref_first;
    logic [BYTE_W-1:0] alt_first;
    logic [BYTE_W-1:0] ref_second;
    logic [BYTE_W-1:0] alt_second;
    logic              ends_site;
    logic              ends_chromosome;
    logic              ends_run;
  } item_t;

  typedef struct packed {
    report_kind_t        report_kind;
    logic [DOSAGE_W-1:0] row_dosage;
    logic [DOSAGE_W-1:0] col_dosage;
    logic [REPORT_W-1:0] matched_count;
    logic [REPORT_W-1:0] compared_count;
    logic                last_report;
  } report_t;

  // Classified item as it travels from the front to the back
  typedef struct packed {
    logic             complete;
    logic             same;
    logic [BIN_W-1:0] bin;
    logic             end_site;
    logic             end_chrom;
    logic             end_run;
  } class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/core/gcc_stream_if.sv @@
// Valid/ready stream interface carrying one payload per beat.
`timescale 1ns / 1ps

interface gcc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/gcc_front.sv @@
// Front end: accept items, build sorted allele pairs and classify them.
`timescale 1ns / 1ps

module gcc_front (
  gcc_stream_if.sink                 items,
  input  gcc_pkg::queue_status_t     q_status,
  output logic                       push,
  output gcc_pkg::class_t            push_data
);

  logic [gcc_pkg::BYTE_W-1:0] f_lo, f_hi, s_lo, s_hi;
  logic [gcc_pkg::BYTE_W-1:0] alt2;
  logic [gcc_pkg::DOSAGE_W-1:0] row, col;
  logic end_chrom;

  // Pick the allele pair for a genotype code and sort it ascending
  function automatic logic [2*gcc_pkg::BYTE_W-1:0] make_pair(
    input logic [gcc_pkg::CODE_W-1:0] code,
    input logic [gcc_pkg::BYTE_W-1:0] refb,
    input logic [gcc_pkg::BYTE_W-1:0] altb
  );
    logic [gcc_pkg::BYTE_W-1:0] a, b;
    case (gcc_pkg::geno_code_t'(code))
      gcc_pkg::CODE_HOM_REF: begin a = refb; b = refb; end
      gcc_pkg::CODE_HET:     begin a = refb; b = altb; end
      gcc_pkg::CODE_HOM_ALT: begin a = altb; b = altb; end
      default:               begin a = '0;   b = '0;   end
    endcase
    if (a > b) begin
      make_pair = {b, a};
    end else begin
      make_pair = {a, b};
    end
  endfunction

  assign items.ready = !q_status.full;
  assign push        = items.valid && !q_status.full;
  assign alt2        = items.data.alt_second;

  assign {f_lo, f_hi} = make_pair(items.data.code_first, items.data.ref_first,
                                  items.data.alt_first);
  assign {s_lo, s_hi} = make_pair(items.data.code_second, items.data.ref_second, alt2);

  // Dosage counted against the second set's alternate allele
  assign row = {1'b0, f_lo == alt2} + {1'b0, f_hi == alt2};
  assign col = {1'b0, s_lo == alt2} + {1'b0, s_hi == alt2};

  // Wider scopes imply closing the narrower ones
  assign end_chrom = items.data.ends_chromosome || items.data.ends_run;

  always_comb begin
    push_data.complete  = (f_lo != '0) && (f_hi != '0) && (s_lo != '0) && (s_hi != '0);
    push_data.same      = (f_lo == s_lo) && (f_hi == s_hi);
    push_data.bin       = gcc_pkg::BIN_W'(row) * gcc_pkg::BIN_W'(3) + gcc_pkg::BIN_W'(col);
    push_data.end_site  = items.data.ends_site || end_chrom;
    push_data.end_chrom = end_chrom;
    push_data.end_run   = items.data.ends_run;
  end

endmodule

@@ rtl/core/gcc_queue.sv @@
// Short FIFO of classified items between the front and the back.
`timescale 1ns / 1ps

module gcc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  gcc_pkg::class_t        push_data,
  input  logic                   pop,
  output gcc_pkg::class_t        pop_data,
  output gcc_pkg::queue_status_t q_status
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  gcc_pkg::class_t    slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push, do_pop;

  assign q_status.full  = (count == COUNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_data       = slots[rd_ptr];

  // Store on push, advance pointers with wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/gcc_back.sv @@
// Back end: update saturating counters and the dosage matrix, emit reports.
`timescale 1ns / 1ps

module gcc_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gcc_pkg::class_t        pop_data,
  input  gcc_pkg::queue_status_t q_status,
  output logic                   pop,
  gcc_stream_if.source           reports
);

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_SITE,
    ST_CHROM,
    ST_TOTAL,
    ST_CELL
  } state_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  state_t state;
  count_t site_matches, site_compared;
  count_t chrom_matches, chrom_compared;
  count_t total_matches, total_compared;
  count_t cells [gcc_pkg::CELLS];

  logic                         held_chrom, held_run;
  logic [gcc_pkg::DOSAGE_W-1:0] cell_row, cell_col;
  logic [gcc_pkg::BIN_W-1:0]    cell_bin;
  logic                         out_free;
  logic                         beat_load;
  logic                         hit, match;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  assign out_free  = !reports.valid || reports.ready;
  assign beat_load = out_free && (state != ST_TAKE);
  assign pop       = (state == ST_TAKE) && !q_status.empty;
  assign hit       = pop && pop_data.complete;
  assign match     = hit && pop_data.same;
  assign cell_bin  = gcc_pkg::BIN_W'(cell_row) * gcc_pkg::BIN_W'(3)
                   + gcc_pkg::BIN_W'(cell_col);

  // Sequencer with counters and the registered report beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_TAKE;
      reports.valid  <= 1'b0;
      site_matches   <= '0;
      site_compared  <= '0;
      chrom_matches  <= '0;
      chrom_compared <= '0;
      total_matches  <= '0;
      total_compared <= '0;
      for (int k = 0; k < gcc_pkg::CELLS; k++) begin
        cells[k] <= '0;
      end
      held_chrom <= 1'b0;
      held_run   <= 1'b0;
      cell_row   <= '0;
      cell_col   <= '0;
    end else begin
      // Raise valid for a new beat, drop it once the waiting beat is taken
      if (beat_load) begin
        reports.valid <= 1'b1;
      end else if (reports.ready) begin
        reports.valid <= 1'b0;
      end
      unique case (state)
        ST_TAKE: begin
          if (hit) begin
            site_compared  <= sat_inc(site_compared);
            chrom_compared <= sat_inc(chrom_compared);
            total_compared <= sat_inc(total_compared);
            for (int k = 0; k < gcc_pkg::CELLS; k++) begin
              if (pop_data.bin == gcc_pkg::BIN_W'(k)) begin
                cells[k] <= sat_inc(cells[k]);
              end
            end
          end
          if (match) begin
            site_matches  <= sat_inc(site_matches);
            chrom_matches <= sat_inc(chrom_matches);
            total_matches <= sat_inc(total_matches);
          end
          if (pop) begin
            held_chrom <= pop_data.end_chrom;
            held_run   <= pop_data.end_run;
            if (pop_data.end_site) begin
              state <= ST_SITE;
            end
          end
        end
        ST_SITE: begin
          if (out_free) begin
            reports.data.report_kind    <= gcc_pkg::KIND_SITE;
            reports.data.row_dosage     <= '0;
            reports.data.col_dosage     <= '0;
            reports.data.matched_count  <= gcc_pkg::REPORT_W'(site_matches);
            reports.data.compared_count <= gcc_pkg::REPORT_W'(site_compared);
            reports.data.last_report    <= !held_chrom;
            site_matches  <= '0;
            site_compared <= '0;
            state <= held_chrom ? ST_CHROM : ST_TAKE;
          end
        end
        ST_CHROM: begin
          if (out_free) begin
            reports.data.report_kind    <= gcc_pkg::KIND_CHROM;
            reports.data.row_dosage     <= '0;
            reports.data.col_dosage     <= '0;
            reports.data.matched_count  <= gcc_pkg::REPORT_W'(chrom_matches);
            reports.data.compared_count <= gcc_pkg::REPORT_W'(chrom_compared);
            reports.data.last_report    <= !held_run;
            chrom_matches  <= '0;
            chrom_compared <= '0;
            state <= held_run ? ST_TOTAL : ST_TAKE;
          end
        end
        ST_TOTAL: begin
          if (out_free) begin
            reports.data.report_kind    <= gcc_pkg::KIND_TOTAL;
            reports.data.row_dosage     <= '0;
            reports.data.col_dosage     <= '0;
            reports.data.matched_count  <= gcc_pkg::REPORT_W'(total_matches);
            reports.data.compared_count <= gcc_pkg::REPORT_W'(total_compared);
            reports.data.last_report    <= 1'b0;
            total_matches  <= '0;
            total_compared <= '0;
            cell_row <= '0;
            cell_col <= '0;
            state    <= ST_CELL;
          end
        end
        ST_CELL: begin
          // Walk the matrix row-major, clearing each cell as it goes out
          if (out_free) begin
            reports.data.report_kind    <= gcc_pkg::KIND_CELL;
            reports.data.row_dosage     <= cell_row;
            reports.data.col_dosage     <= cell_col;
            reports.data.matched_count  <= gcc_pkg::REPORT_W'(cells[cell_bin]);
            reports.data.compared_count <= '0;
            reports.data.last_report    <= (cell_row == gcc_pkg::DOSAGE_MAX)
                                        && (cell_col == gcc_pkg::DOSAGE_MAX);
            cells[cell_bin] <= '0;
            if (cell_col == gcc_pkg::DOSAGE_MAX) begin
              cell_col <= '0;
              if (cell_row == gcc_pkg::DOSAGE_MAX) begin
                cell_row <= '0;
                state    <= ST_TAKE;
              end else begin
                cell_row <= cell_row + 1'b1;
              end
            end else begin
              cell_col <= cell_col + 1'b1;
            end
          end
        end
        default: state <= ST_TAKE;
      endcase
    end
  end

endmodule

@@ rtl/core/genotype_concordance_counter.sv @@
// Top level of the genotype concordance counter.
//
//   channel   dir  payload               beat when
//   items     in   gcc_pkg::item_t       items.valid && items.ready
//   reports   out  gcc_pkg::report_t     reports.valid && reports.ready
//
// An item with no end flag leaves the back end in its take state, so such items
// stream at one per cycle. An item that closes scopes holds the back end while
// it emits one report per closed scope, and at the end of a run the nine matrix
// cells too: up to 12 reports. The queue between front and back keeps accepting
// items meanwhile, until full. A stalled report beat holds in its output
// register. Synchronous reset clears all counters and the matrix.
`timescale 1ns / 1ps

module genotype_concordance_counter #(
  parameter int COUNT_WIDTH = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  gcc_stream_if.sink   items,
  gcc_stream_if.source reports
);

  logic                   push, pop;
  gcc_pkg::class_t        push_data, pop_data;
  gcc_pkg::queue_status_t q_status;

  gcc_front u_front (
    .items     (items),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  gcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  gcc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .q_status (q_status),
    .pop      (pop),
    .reports  (reports)
  );

  // Scope reports carry no matrix coordinates
  a_scope_no_coords: assert property (@(posedge clk) disable iff (rst)
    reports.valid && (reports.data.report_kind != gcc_pkg::KIND_CELL)
    |-> (reports.data.row_dosage == '0) && (reports.data.col_dosage == '0))
    else $error("scope report with nonzero matrix coordinates");

  // Matrix cells carry no comparison count
  a_cell_no_compared: assert property (@(posedge clk) disable iff (rst)
    reports.valid && (reports.data.report_kind == gcc_pkg::KIND_CELL)
    |-> (reports.data.compared_count == '0))
    else $error("matrix cell with nonzero compared count");

  // The last matrix cell is the bottom-right one
  a_cell_last: assert property (@(posedge clk) disable iff (rst)
    reports.valid && reports.data.last_report
    && (reports.data.report_kind == gcc_pkg::KIND_CELL)
    |-> (reports.data.row_dosage == gcc_pkg::DOSAGE_MAX)
     && (reports.data.col_dosage == gcc_pkg::DOSAGE_MAX))
    else $error("matrix flush ended on the wrong cell");

  // Queue cannot be full and empty together
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

endmodule
